[design/ccrc_pkg.sv]
// Shared types and constants of the configurable CRC-32 engine.
`default_nettype none
package ccrc_pkg;

	// Width of the CRC register and of the wide configuration registers.
	localparam int unsigned CRC_W  = 32;
	localparam int unsigned BYTE_W = 8;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_XOR_OUT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REFLECTED  = 2'd3;

	// Register values after reset (the usual CRC-32 setup).
	localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] XOR_RESET  = 32'hFFFF_FFFF;
	localparam logic             REFL_RESET = 1'b1;

	// Settings that the byte fold needs.
	typedef struct packed {
		logic [CRC_W-1:0] poly;
		logic             reflected;
	} ccrc_fold_cfg_t;

endpackage
`default_nettype wire

[design/ccrc_fold.sv]
// Folds one message byte into a 32-bit CRC register in eight unrolled shift-and-XOR steps.
`default_nettype none
module ccrc_fold (
	input  wire ccrc_pkg::ccrc_fold_cfg_t    cfg,
	input  wire [ccrc_pkg::CRC_W-1:0]        crc_in,
	input  wire [ccrc_pkg::BYTE_W-1:0]       data,
	output logic [ccrc_pkg::CRC_W-1:0]       crc_out
);

	logic [ccrc_pkg::CRC_W-1:0] rpoly;

	// Bit-reversed polynomial for the LSB-first order.
	always_comb begin
		for (int k = 0; k < ccrc_pkg::CRC_W; k++) begin
			rpoly[k] = cfg.poly[ccrc_pkg::CRC_W-1-k];
		end
	end

	// Eight dependent steps, one per message bit.
	always_comb begin
		logic [ccrc_pkg::CRC_W-1:0] r;
		r = crc_in;
		if (cfg.reflected) begin
			r[ccrc_pkg::BYTE_W-1:0] = r[ccrc_pkg::BYTE_W-1:0] ^ data;
			for (int k = 0; k < ccrc_pkg::BYTE_W; k++) begin
				if (r[0]) begin
					r = (r >> 1) ^ rpoly;
				end else begin
					r = r >> 1;
				end
			end
		end else begin
			r[ccrc_pkg::CRC_W-1 -: ccrc_pkg::BYTE_W] =
				r[ccrc_pkg::CRC_W-1 -: ccrc_pkg::BYTE_W] ^ data;
			for (int k = 0; k < ccrc_pkg::BYTE_W; k++) begin
				if (r[ccrc_pkg::CRC_W-1]) begin
					r = (r << 1) ^ cfg.poly;
				end else begin
					r = r << 1;
				end
			end
		end
		crc_out = r;
	end

endmodule
`default_nettype wire

[design/configurable_crc32_engine.sv]
// Top level of the configurable CRC-32 engine: input stage, fold, CRC register and result register.
// The engine takes one message byte per clock cycle and produces one CRC per message, on the
// beat marked last_byte. A byte is captured in an input register and folded into the running
// CRC through eight unrolled shift-and-XOR steps as it leaves that register; the final value is
// held in the result register on the result port. The input keeps accepting one byte per cycle
// while a result waits to be taken; only a second last byte that meets a full result register
// stalls. Polynomial, initial value, output XOR and bit order are set through the write port
// (index 0 to 3) only while no message is in flight: a user's rule the block does not enforce.
`default_nettype none
module configurable_crc32_engine (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Configuration write port.
	input  wire                                 cfg_we,
	input  wire [ccrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [ccrc_pkg::CRC_W-1:0]           cfg_data,
	// Byte input channel.
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire [ccrc_pkg::BYTE_W-1:0]          data_byte,
	input  wire                                 first_byte,
	input  wire                                 last_byte,
	// Result channel.
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [ccrc_pkg::CRC_W-1:0]          crc_value
);

	logic [ccrc_pkg::CRC_W-1:0]  poly_q;
	logic [ccrc_pkg::CRC_W-1:0]  init_q;
	logic [ccrc_pkg::CRC_W-1:0]  xor_q;
	logic                        refl_q;

	logic                        valid_s1;
	logic [ccrc_pkg::BYTE_W-1:0] byte_s1;
	logic                        first_s1;
	logic                        last_s1;

	logic [ccrc_pkg::CRC_W-1:0]  running_crc_q;
	logic                        out_valid_q;
	logic [ccrc_pkg::CRC_W-1:0]  crc_q;

	logic                        out_free;
	logic                        s1_fire;
	logic [ccrc_pkg::CRC_W-1:0]  start_crc;
	logic [ccrc_pkg::CRC_W-1:0]  next_crc;
	ccrc_pkg::ccrc_fold_cfg_t    fold_cfg;

	// Configuration registers; the two-bit index covers all four registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= ccrc_pkg::POLY_RESET;
			init_q <= ccrc_pkg::INIT_RESET;
			xor_q  <= ccrc_pkg::XOR_RESET;
			refl_q <= ccrc_pkg::REFL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ccrc_pkg::CFG_POLYNOMIAL: poly_q <= cfg_data;
				ccrc_pkg::CFG_INIT_VALUE: init_q <= cfg_data;
				ccrc_pkg::CFG_XOR_OUT:    xor_q  <= cfg_data;
				ccrc_pkg::CFG_REFLECTED:  refl_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: a last byte may only leave the input stage when the result slot frees up.
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// A first byte restarts from init XOR xor_out.
	assign start_crc      = first_s1 ? (init_q ^ xor_q) : running_crc_q;
	assign fold_cfg.poly      = poly_q;
	assign fold_cfg.reflected = refl_q;

	ccrc_fold u_fold (
		.cfg     (fold_cfg),
		.crc_in  (start_crc),
		.data    (byte_s1),
		.crc_out (next_crc)
	);

	// Running CRC register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
		end else if (s1_fire) begin
			running_crc_q <= next_crc;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			crc_q <= next_crc ^ xor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

	// A new result beat always comes from a last byte leaving the input stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result beat appeared without a last byte");

	// A held byte in the input stage keeps its contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a held byte");

	// The running CRC only moves when a byte is folded in.
	a_crc_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(running_crc_q))
		else $error("running CRC changed without a byte");

	// An accepted byte always lands in the input stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted byte did not reach the input stage");

	// A pending result is never overwritten while the output is stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(crc_q))
		else $error("pending result overwritten");

endmodule
`default_nettype wire
